// ===== hdl/dle_pkg.sv =====
// Shared types, codes and opcode decode for the location-expression encoder.
`timescale 1ns / 1ps

package dle_pkg;

  // Request kinds carried on in_tuser
  localparam logic [1:0] REQ_GENERIC = 2'd0;
  localparam logic [1:0] REQ_ADDR    = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  localparam logic [7:0] OP_ADDR   = 8'h03;
  localparam logic [31:0] NO_SYMBOL = 32'd0;

  // Configuration register index (byte address bit 2)
  localparam logic REG_BYTE_ORDER = 1'b0;

  // Result byte count of one item: up to 21, so 5 bits
  localparam int NB_W = 5;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_OP   = 3'd1,
    ST_ADDR_GEN = 3'd2,
    ST_CONST8   = 3'd3,
    ST_BRANCH   = 3'd4,
    ST_TOO_LONG = 3'd5,
    ST_RELOC2   = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    CL_NONE,
    CL_SLEB,
    CL_ULEB,
    CL_FIX1,
    CL_FIX2,
    CL_FIX4,
    CL_BREGX,
    CL_ADDR,
    CL_CONST8,
    CL_BRANCH,
    CL_BAD
  } op_class_t;

  typedef enum logic [1:0] {
    MD_LEB,
    MD_FIX_LE,
    MD_FIX_BE
  } shift_mode_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic check;
    logic step;
  } dle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_byte;
  } dle_sts_t;

  function automatic op_class_t op_class(input logic [7:0] op);
    op_class_t c;
    unique case (op) inside
      [8'h12:8'h14], [8'h16:8'h22], [8'h24:8'h27], [8'h29:8'h2e],
      [8'h30:8'h6f], 8'h06, 8'h96:      c = CL_NONE;
      [8'h70:8'h8f], 8'h11, 8'h91:      c = CL_SLEB;
      8'h10, 8'h23, 8'h90, 8'h93:       c = CL_ULEB;
      8'h08, 8'h09, 8'h15, 8'h94, 8'h95: c = CL_FIX1;
      8'h0a, 8'h0b:                     c = CL_FIX2;
      8'h0c, 8'h0d:                     c = CL_FIX4;
      8'h92:                            c = CL_BREGX;
      OP_ADDR:                          c = CL_ADDR;
      8'h0e, 8'h0f:                     c = CL_CONST8;
      8'h28, 8'h2f:                     c = CL_BRANCH;
      default:                          c = CL_BAD;
    endcase
    return c;
  endfunction

  // Unsigned LEB128 byte count: one past the highest nonzero 7-bit group
  function automatic logic [3:0] uleb_len(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int k = 1; k < 10; k++) begin
      if ((v >> (7 * k)) != 64'd0) n = 4'(k + 1);
    end
    return n;
  endfunction

  // Signed LEB128 byte count: fewest n with bits [63:7n-1] all equal
  function automatic logic [3:0] sleb_len(input logic [63:0] v);
    logic [3:0]  n;
    logic [63:0] t;
    n = 4'd10;
    for (int k = 9; k >= 1; k--) begin
      t = 64'($signed(v) >>> (7 * k - 1));
      if (t == 64'd0 || t == {64{1'b1}}) n = 4'(k);
    end
    return n;
  endfunction

endpackage

// ===== hdl/dwarf_loc_expr_encoder.sv =====
// Top level of the DWARF location-expression encoder with LEB128 operands.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// in_       in   tvalid / tready    tdata: opcode, val1, val2, address, symbol
//                                   tuser: req_type
// out_      out  tvalid / tready    tdata: byte, offset, status, length, reloc
//                                   tlast: final result of the item
// cfg_      in   APB psel/penable   byte_order at byte address 0
//
// Each item is accepted in the idle state, checked in the check state and
// then emitted, one result byte per cycle while out_tready does not stall
// (up to 21 bytes for bregx); the byte shifter loaded at check sets the pace.
// The next item is taken the cycle after its predecessor's final result enters
// the output register, even while that result still waits.
// A stalled out_tready holds the output register and freezes emission.
// Reset is synchronous: length 0, no relocation, little endian.

module dwarf_loc_expr_encoder #(
  parameter int MAX_EXPR_BYTES = 64
) (
  input  logic         clk,
  input  logic         rst_n,

  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] opcode, [71:8] val1, [135:72] val2, [167:136] address,
  // [199:168] symbol
  input  logic [199:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]   in_tuser,

  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] out_byte, [13:8] byte_offset, [16:14] status, [23:17] expr_length,
  // [30:24] reloc_position, [62:31] reloc_symbol, [63] zero
  output logic [63:0]  out_tdata,
  output logic         out_tlast,

  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import dle_pkg::*;

  dle_cmd_t    cmd;
  dle_sts_t    sts;
  logic        byte_order_r;
  logic        cfg_wr;
  logic [7:0]  o_byte;
  logic [5:0]  o_offset;
  logic [2:0]  o_status;
  logic [6:0]  o_length;
  logic [6:0]  o_rpos;
  logic [31:0] o_rsym;

  // Configuration: one word, written in the APB access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_BYTE_ORDER) ? {31'd0, byte_order_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[2] == REG_BYTE_ORDER) begin
      byte_order_r <= cfg_pwdata[0];
    end
  end

  dle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dle_dp #(
    .MAX_EXPR_BYTES (MAX_EXPR_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .byte_order         (byte_order_r),
    .in_req_type        (in_tuser),
    .in_payload         (in_tdata),
    .out_byte           (o_byte),
    .out_byte_offset    (o_offset),
    .out_last           (out_tlast),
    .out_status         (o_status),
    .out_expr_length    (o_length),
    .out_reloc_position (o_rpos),
    .out_reloc_symbol   (o_rsym)
  );

  // Pack the result fields from the lowest bit up
  assign out_tdata = {1'b0, o_rsym, o_rpos, o_length, o_status, o_offset, o_byte};

endmodule

// ===== hdl/dle_ctrl.sv =====
// Sequencer for the location-expression encoder: accept, check, emit bytes.
`timescale 1ns / 1ps

module dle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  dle_pkg::dle_sts_t sts,
  output dle_pkg::dle_cmd_t cmd
);
  import dle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    cmd.capture = in_tvalid && (state_r == S_IDLE);
    cmd.check   = (state_r == S_CHECK);
    cmd.step    = (state_r == S_EMIT) && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_CHECK;
      S_CHECK: state_nxt = S_EMIT;
      S_EMIT:  if (cmd.step && sts.last_byte) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted item is always checked in the next cycle
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CHECK))
    else $error("accepted item not followed by check");

  // The final byte of an item frees the input side in the next cycle
  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.last_byte) |=> in_tready)
    else $error("input not ready after final byte");

  // A byte never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !cmd.step)
    else $error("output register overwritten while stalled");

endmodule

// ===== hdl/dle_dp.sv =====
// Datapath: item registers, length check, expression state and byte shifter.
`timescale 1ns / 1ps

module dle_dp #(
  parameter int MAX_EXPR_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dle_pkg::dle_cmd_t cmd,
  output dle_pkg::dle_sts_t sts,
  input  logic              byte_order,
  input  logic [1:0]        in_req_type,
  input  logic [199:0]      in_payload,
  output logic [7:0]        out_byte,
  output logic [5:0]        out_byte_offset,
  output logic              out_last,
  output logic [2:0]        out_status,
  output logic [6:0]        out_expr_length,
  output logic [6:0]        out_reloc_position,
  output logic [31:0]       out_reloc_symbol
);
  import dle_pkg::*;

  localparam int OFFW = $clog2(MAX_EXPR_BYTES + 1);
  localparam int SUMW = OFFW + 1;
  localparam int EXTW = (OFFW > 7) ? OFFW : 7;

  // Captured item
  logic [1:0]  req_r;
  logic [7:0]  op_r;
  logic [63:0] v1_r;
  logic [63:0] v2_r;
  logic [31:0] addr_r;
  logic [31:0] sym_r;

  // Expression state
  logic [OFFW-1:0] next_off_r;
  logic [OFFW-1:0] reloc_off_r;
  logic [31:0]     reloc_sym_r;

  // Emission state
  logic [OFFW-1:0] start_r;
  logic [NB_W-1:0] n_r, n1_r, idx_r;
  logic [63:0]     sh_r;
  shift_mode_t     mode_r;
  status_t         st_r;
  logic            zero_r, is_addr_r, bregx_r, sgn_r;

  // Check-cycle decode
  op_class_t       cls;
  logic [3:0]      ulen1, slen1, slen2;
  logic [NB_W-1:0] m, n_chk, n1_chk;
  logic [SUMW-1:0] sum;
  logic            too_long, ok_emit, fixed;
  status_t         status;
  logic [63:0]     sh_load;

  // Step
  logic [7:0]      byte_nxt;
  logic            cont;
  logic [NB_W-1:0] last_idx;
  logic [OFFW-1:0] pos;
  logic [EXTW-1:0] pos_ext, len_ext, rpos_ext;

  always_comb begin
    cls   = op_class(op_r);
    ulen1 = uleb_len(v1_r);
    slen1 = sleb_len(v1_r);
    slen2 = sleb_len(v2_r);

    case (cls)
      CL_SLEB:  m = NB_W'(slen1);
      CL_ULEB:  m = NB_W'(ulen1);
      CL_FIX1:  m = NB_W'(1);
      CL_FIX2:  m = NB_W'(2);
      CL_FIX4:  m = NB_W'(4);
      CL_BREGX: m = NB_W'(ulen1) + NB_W'(slen2);
      default:  m = '0;
    endcase

    n_chk    = (req_r == REQ_ADDR) ? NB_W'(5) : m + NB_W'(1);
    sum      = SUMW'(next_off_r) + SUMW'(n_chk);
    too_long = sum > SUMW'(MAX_EXPR_BYTES);

    unique case (req_r)
      REQ_CLEAR: status = ST_OK;
      REQ_ADDR: begin
        if (too_long) status = ST_TOO_LONG;
        else if (reloc_off_r != '0) status = ST_RELOC2;
        else status = ST_OK;
      end
      REQ_GENERIC: begin
        case (cls)
          CL_BAD:    status = ST_BAD_OP;
          CL_ADDR:   status = ST_ADDR_GEN;
          CL_CONST8: status = ST_CONST8;
          CL_BRANCH: status = ST_BRANCH;
          default:   status = too_long ? ST_TOO_LONG : ST_OK;
        endcase
      end
      default: status = ST_BAD_OP;
    endcase
    ok_emit = (status == ST_OK) && (req_r != REQ_CLEAR);

    n1_chk = (cls == CL_BREGX && req_r == REQ_GENERIC) ? NB_W'(ulen1)
                                                       : n_chk - NB_W'(1);

    // Fixed-width operands: big endian loads left-aligned and shifts left
    fixed = (req_r == REQ_ADDR) || cls == CL_FIX1 || cls == CL_FIX2 ||
            cls == CL_FIX4;
    if (req_r == REQ_ADDR) begin
      sh_load = byte_order ? {addr_r, 32'd0} : {32'd0, addr_r};
    end else if (byte_order && cls == CL_FIX1) begin
      sh_load = {v1_r[7:0], 56'd0};
    end else if (byte_order && cls == CL_FIX2) begin
      sh_load = {v1_r[15:0], 48'd0};
    end else if (byte_order && cls == CL_FIX4) begin
      sh_load = {v1_r[31:0], 32'd0};
    end else begin
      sh_load = v1_r;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req_type;
      op_r   <= in_payload[7:0];
      v1_r   <= in_payload[71:8];
      v2_r   <= in_payload[135:72];
      addr_r <= in_payload[167:136];
      sym_r  <= in_payload[199:168];
    end
  end

  // Expression state: commit at check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_off_r  <= '0;
      reloc_off_r <= '0;
      reloc_sym_r <= NO_SYMBOL;
    end else if (cmd.check) begin
      if (req_r == REQ_CLEAR) begin
        next_off_r  <= '0;
        reloc_off_r <= '0;
        reloc_sym_r <= NO_SYMBOL;
      end else if (ok_emit) begin
        next_off_r <= sum[OFFW-1:0];
        if (req_r == REQ_ADDR) begin
          reloc_off_r <= next_off_r + OFFW'(1);
          reloc_sym_r <= sym_r;
        end
      end
    end
  end

  always_comb begin
    last_idx = n_r - NB_W'(1);
    cont     = (idx_r != n1_r) && (idx_r != last_idx);
    if (idx_r == '0) begin
      byte_nxt = zero_r ? 8'd0 : (is_addr_r ? OP_ADDR : op_r);
    end else begin
      case (mode_r)
        MD_FIX_LE: byte_nxt = sh_r[7:0];
        MD_FIX_BE: byte_nxt = sh_r[63:56];
        default:   byte_nxt = {cont, sh_r[6:0]};
      endcase
    end
    pos      = start_r + OFFW'(idx_r);
    pos_ext  = EXTW'(pos);
    len_ext  = EXTW'(next_off_r);
    rpos_ext = EXTW'(reloc_off_r);
    sts.last_byte = (idx_r == last_idx);
  end

  // Emission sequencing and byte shifter; signed LEB128 shifts in the sign
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      st_r      <= status;
      zero_r    <= !ok_emit;
      n_r       <= ok_emit ? n_chk : NB_W'(1);
      n1_r      <= n1_chk;
      idx_r     <= '0;
      sh_r      <= sh_load;
      mode_r    <= fixed ? (byte_order ? MD_FIX_BE : MD_FIX_LE) : MD_LEB;
      is_addr_r <= (req_r == REQ_ADDR);
      bregx_r   <= (req_r == REQ_GENERIC) && (cls == CL_BREGX);
      sgn_r     <= (req_r == REQ_GENERIC) && (cls == CL_SLEB);
      start_r   <= (req_r == REQ_CLEAR) ? '0 : next_off_r;
    end else if (cmd.step) begin
      idx_r <= idx_r + NB_W'(1);
      if (idx_r != '0) begin
        case (mode_r)
          MD_FIX_LE: sh_r <= sh_r >> 8;
          MD_FIX_BE: sh_r <= sh_r << 8;
          default: begin
            if (bregx_r && idx_r == n1_r) begin
              sh_r  <= v2_r;
              sgn_r <= 1'b1;
            end else if (sgn_r) begin
              sh_r <= 64'($signed(sh_r) >>> 7);
            end else begin
              sh_r <= sh_r >> 7;
            end
          end
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_byte           <= byte_nxt;
      out_byte_offset    <= pos_ext[5:0];
      out_last           <= sts.last_byte;
      out_status         <= st_r;
      out_expr_length    <= len_ext[6:0];
      out_reloc_position <= rpos_ext[6:0];
      out_reloc_symbol   <= reloc_sym_r;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SUMW'(next_off_r) <= SUMW'(MAX_EXPR_BYTES))
    else $error("expression length beyond buffer");

  // The relocated address lies wholly inside the expression
  a_reloc_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (reloc_off_r != '0) |-> (SUMW'(reloc_off_r) + SUMW'(4) <= SUMW'(next_off_r)))
    else $error("relocation outside expression");

  // Every emitted byte of an accepted item falls below the committed length
  a_pos_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !zero_r) |-> (SUMW'(start_r) + SUMW'(idx_r) < SUMW'(next_off_r)))
    else $error("emitted byte beyond expression length");

endmodule

// ===== test/tb_dwarf_loc_expr_encoder.sv =====
// Self-checking testbench for the DWARF location-expression encoder.
`timescale 1ns / 1ps

module tb_dwarf_loc_expr_encoder;
  import dle_pkg::*;

  localparam int EXPR_CAP   = 64;
  localparam int N_PHASES   = 5;
  localparam int PHASE_REQS = 90;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] BYTE_ORDER_ADDR = {REG_BYTE_ORDER, 2'b00};

  // Request kind that the block must reject as a bad operation
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  // DWARF location operation codes used by the stimulus and the predictor
  localparam logic [7:0] OPC_DEREF       = 8'h06;
  localparam logic [7:0] OPC_CONST1U     = 8'h08;
  localparam logic [7:0] OPC_CONST1S     = 8'h09;
  localparam logic [7:0] OPC_CONST2U     = 8'h0a;
  localparam logic [7:0] OPC_CONST2S     = 8'h0b;
  localparam logic [7:0] OPC_CONST4U     = 8'h0c;
  localparam logic [7:0] OPC_CONST4S     = 8'h0d;
  localparam logic [7:0] OPC_CONST8U     = 8'h0e;
  localparam logic [7:0] OPC_CONST8S     = 8'h0f;
  localparam logic [7:0] OPC_CONSTU      = 8'h10;
  localparam logic [7:0] OPC_CONSTS      = 8'h11;
  localparam logic [7:0] OPC_DUP         = 8'h12;
  localparam logic [7:0] OPC_OVER        = 8'h14;
  localparam logic [7:0] OPC_PICK        = 8'h15;
  localparam logic [7:0] OPC_SWAP        = 8'h16;
  localparam logic [7:0] OPC_PLUS        = 8'h22;
  localparam logic [7:0] OPC_PLUS_UCONST = 8'h23;
  localparam logic [7:0] OPC_SHL         = 8'h24;
  localparam logic [7:0] OPC_XOR         = 8'h27;
  localparam logic [7:0] OPC_BRA         = 8'h28;
  localparam logic [7:0] OPC_EQ          = 8'h29;
  localparam logic [7:0] OPC_NE          = 8'h2e;
  localparam logic [7:0] OPC_SKIP        = 8'h2f;
  localparam logic [7:0] OPC_LIT0        = 8'h30;
  localparam logic [7:0] OPC_REG31       = 8'h6f;
  localparam logic [7:0] OPC_BREG0       = 8'h70;
  localparam logic [7:0] OPC_BREG31      = 8'h8f;
  localparam logic [7:0] OPC_REGX        = 8'h90;
  localparam logic [7:0] OPC_FBREG       = 8'h91;
  localparam logic [7:0] OPC_BREGX       = 8'h92;
  localparam logic [7:0] OPC_PIECE       = 8'h93;
  localparam logic [7:0] OPC_DEREF_SIZE  = 8'h94;
  localparam logic [7:0] OPC_XDEREF_SIZE = 8'h95;
  localparam logic [7:0] OPC_NOP         = 8'h96;
  localparam logic [7:0] OPC_UNUSED      = 8'hff;

  localparam logic [7:0] PLAIN_OPS [10] = '{OPC_DEREF, OPC_DUP, OPC_OVER, OPC_SWAP,
    OPC_PLUS, OPC_SHL, OPC_XOR, OPC_EQ, OPC_NE, OPC_NOP};
  localparam logic [7:0] SIZED_OPS [3] = '{OPC_PICK, OPC_DEREF_SIZE, OPC_XDEREF_SIZE};
  localparam logic [7:0] FAULT_OPS [5] = '{OPC_CONST8U, OPC_CONST8S, OPC_BRA, OPC_SKIP,
    OP_ADDR};

  // Idle percentages per random phase: none, sender, receiver, both, pressure
  localparam int SEND_IDLE  [N_PHASES] = '{0, 55, 0, 36, 0};
  localparam int RECV_STALL [N_PHASES] = '{0, 0, 55, 36, 20};

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  opcode;
    logic [63:0] val1;
    logic [63:0] val2;
    logic [31:0] address;
    logic [31:0] symbol;
  } loc_req_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [5:0]  offset;
    logic        last;
    status_t     status;
    logic [6:0]  length;
    logic [6:0]  reloc_pos;
    logic [31:0] reloc_sym;
  } enc_byte_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // [7:0] opcode, [71:8] val1, [135:72] val2, [167:136] address, [199:168] symbol
  logic [199:0] in_tdata = '0;
  // [1:0] req_type
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [7:0] out_byte, [13:8] byte_offset, [16:14] status, [23:17] expr_length,
  // [30:24] reloc_position, [62:31] reloc_symbol, [63] zero
  logic [63:0]  out_tdata;
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  dwarf_loc_expr_encoder #(
    .MAX_EXPR_BYTES(EXPR_CAP)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Stimulus queue, the item on the bus and the bytes still owed by the block
  loc_req_t  pending_reqs[$];
  loc_req_t  offer = '0;
  logic      offer_live = 1'b0;
  enc_byte_t expected_bytes[$];

  // Idle control; the percentages are written by the sequencer while the block is drained
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_left = 0;

  int err_count = 0;
  int items_taken = 0;
  int bytes_checked = 0;
  int status_hits[8] = '{default: 0};

  // Shadow state of the encoder
  int         expr_len = 0;
  int         reloc_pos = 0;
  logic [31:0] reloc_sym = NO_SYMBOL;
  logic       big_endian = 1'b0;
  logic [7:0] op_bytes[$];

  // Append an unsigned LEB128 value to the bytes of the current item
  function automatic void put_uleb(input logic [63:0] v);
    logic [7:0] c;
    do begin
      c = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 64'd0) c[7] = 1'b1;
      op_bytes.push_back(c);
    end while (v != 64'd0);
  endfunction

  // Signed LEB128: stop once the remaining bits are pure sign extension
  function automatic void put_sleb(input logic [63:0] v);
    logic [7:0] c;
    logic       done;
    done = 1'b0;
    while (!done) begin
      c = {1'b0, v[6:0]};
      v = {{7{v[63]}}, v[63:7]};
      done = (v == '0 && !c[6]) || (v == '1 && c[6]);
      if (!done) c[7] = 1'b1;
      op_bytes.push_back(c);
    end
  endfunction

  function automatic void put_fixed(input logic [63:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++)
      op_bytes.push_back(v[(big_endian ? nbytes - 1 - i : i) * 8 +: 8]);
  endfunction

  // Operand bytes of a generic operation; returns the status it earns
  function automatic status_t generic_operands(input loc_req_t r);
    case (r.opcode) inside
      [OPC_DUP:OPC_OVER], [OPC_SWAP:OPC_PLUS], [OPC_SHL:OPC_XOR], [OPC_EQ:OPC_NE],
      [OPC_LIT0:OPC_REG31], OPC_DEREF, OPC_NOP: ;
      [OPC_BREG0:OPC_BREG31], OPC_CONSTS, OPC_FBREG: put_sleb(r.val1);
      OPC_CONSTU, OPC_PLUS_UCONST, OPC_REGX, OPC_PIECE: put_uleb(r.val1);
      OPC_CONST1U, OPC_CONST1S: put_fixed(r.val1, 1);
      OPC_CONST2U, OPC_CONST2S: put_fixed(r.val1, 2);
      OPC_CONST4U, OPC_CONST4S: put_fixed(r.val1, 4);
      OPC_PICK, OPC_DEREF_SIZE, OPC_XDEREF_SIZE: op_bytes.push_back(r.val1[7:0]);
      OPC_BREGX: begin
        put_uleb(r.val1);
        put_sleb(r.val2);
      end
      OP_ADDR: return ST_ADDR_GEN;
      OPC_CONST8U, OPC_CONST8S: return ST_CONST8;
      OPC_BRA, OPC_SKIP: return ST_BRANCH;
      default: return ST_BAD_OP;
    endcase
    return ST_OK;
  endfunction

  // Work out the result bytes of one accepted item and update the shadow state
  function automatic void encode_request(input loc_req_t r);
    status_t st;
    int      start;
    start = expr_len;
    st = ST_OK;
    op_bytes.delete();
    if (r.kind == REQ_CLEAR) begin
      expr_len = 0;
      reloc_pos = 0;
      reloc_sym = NO_SYMBOL;
      status_hits[ST_OK]++;
      expected_bytes.push_back('{8'd0, 6'd0, 1'b1, ST_OK, 7'd0, 7'd0, NO_SYMBOL});
      return;
    end
    if (r.kind == REQ_RESERVED) begin
      st = ST_BAD_OP;
    end else if (r.kind == REQ_ADDR) begin
      // Length is checked before the relocation slot
      if (start + 5 > EXPR_CAP) st = ST_TOO_LONG;
      else if (reloc_pos != 0) st = ST_RELOC2;
      else begin
        op_bytes.push_back(OP_ADDR);
        put_fixed({32'd0, r.address}, 4);
      end
    end else begin
      op_bytes.push_back(r.opcode);
      st = generic_operands(r);
      if (st == ST_OK && start + op_bytes.size() > EXPR_CAP) st = ST_TOO_LONG;
    end
    status_hits[st]++;
    // A rejected item leaves the state alone and reports the current length
    if (st != ST_OK) begin
      expected_bytes.push_back('{8'd0, 6'(start), 1'b1, st, 7'(start), 7'(reloc_pos),
                                 reloc_sym});
      return;
    end
    if (r.kind == REQ_ADDR) begin
      reloc_pos = start + 1;
      reloc_sym = r.symbol;
    end
    expr_len = start + op_bytes.size();
    foreach (op_bytes[i])
      expected_bytes.push_back('{op_bytes[i], 6'(start + i), i == op_bytes.size() - 1,
                                 ST_OK, 7'(expr_len), 7'(reloc_pos), reloc_sym});
  endfunction

  function automatic loc_req_t mk(input logic [1:0] kind, input logic [7:0] op,
                                  input logic [63:0] v1, input logic [63:0] v2,
                                  input logic [31:0] addr, input logic [31:0] sym);
    return '{kind, op, v1, v2, addr, sym};
  endfunction

  // Mix of extremes and values of every LEB128 length
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2: v = 64'h8000_0000_0000_0000;
      3: v = 64'h7fff_ffff_ffff_ffff;
      default: begin
        v = {$urandom, $urandom} >> $urandom_range(63);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Favor operations with operands; keep a share of arbitrary and faulty codes
  function automatic logic [7:0] rand_opcode();
    case ($urandom_range(15))
      0, 1:   return 8'($urandom);
      2, 3:   return OPC_BREG0 + 8'($urandom_range(31));
      4, 5:   return OPC_BREGX;
      6, 7:   return OPC_CONST1U + 8'($urandom_range(5));
      8:      return $urandom_range(1) ? OPC_CONSTU : OPC_PLUS_UCONST;
      9:      return $urandom_range(1) ? OPC_CONSTS : OPC_FBREG;
      10:     return $urandom_range(1) ? OPC_REGX : OPC_PIECE;
      11:     return SIZED_OPS[$urandom_range(2)];
      12, 13: return OPC_LIT0 + 8'($urandom_range(63));
      14:     return PLAIN_OPS[$urandom_range(9)];
      default: return FAULT_OPS[$urandom_range(4)];
    endcase
  endfunction

  // Clears are rare enough that expressions run into the length limit
  function automatic loc_req_t rand_request();
    loc_req_t r;
    int       roll;
    roll = $urandom_range(99);
    r.kind = roll < 7 ? REQ_CLEAR : roll < 16 ? REQ_ADDR :
             roll < 18 ? REQ_RESERVED : REQ_GENERIC;
    r.opcode = (r.kind == REQ_GENERIC) ? rand_opcode() : 8'($urandom);
    r.val1 = rand_value();
    r.val2 = rand_value();
    r.address = $urandom;
    r.symbol = $urandom;
    return r;
  endfunction

  // Predict on acceptance; free the bus slot for the next item
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      encode_request(offer);
      items_taken++;
      offer_live = 1'b0;
    end
  end

  // Driver: hold an offered item until taken, insert random gaps between items
  always @(negedge clk) begin
    if (rst_n && !offer_live && pending_reqs.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      offer = pending_reqs.pop_front();
      offer_live = 1'b1;
    end
    in_tvalid <= offer_live;
    in_tuser  <= offer.kind;
    in_tdata  <= {offer.symbol, offer.address, offer.val2, offer.val1, offer.opcode};
  end

  // Receiver: a long hold when requested, random stalls otherwise
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare every accepted result with the oldest expectation
  always @(posedge clk) begin : watch_results
    enc_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("result with nothing expected: tdata %h tlast %b", out_tdata, out_tlast);
        err_count++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (out_tdata[7:0] !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_tdata[7:0]);
          err_count++;
        end
        if (out_tdata[13:8] !== want.offset) begin
          $error("byte_offset: expected %0d, got %0d", want.offset, out_tdata[13:8]);
          err_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_tlast);
          err_count++;
        end
        if (out_tdata[16:14] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[16:14]);
          err_count++;
        end
        if (out_tdata[23:17] !== want.length) begin
          $error("expr_length: expected %0d, got %0d", want.length, out_tdata[23:17]);
          err_count++;
        end
        if (out_tdata[30:24] !== want.reloc_pos) begin
          $error("reloc_position: expected %0d, got %0d", want.reloc_pos, out_tdata[30:24]);
          err_count++;
        end
        if (out_tdata[62:31] !== want.reloc_sym) begin
          $error("reloc_symbol: expected %h, got %h", want.reloc_sym, out_tdata[62:31]);
          err_count++;
        end
      end
    end
  end

  // Write byte_order over the config port, then read it back
  task automatic program_byte_order(input logic bo);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= BYTE_ORDER_ADDR;
    cfg_pwdata  <= {31'($urandom), bo};
    @(negedge clk) cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    big_endian = bo;
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk) cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[0] !== bo) begin
      $error("byte_order readback: expected %b, got %b", bo, cfg_prdata[0]);
      err_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Hold until every queued item is taken and every owed result has arrived
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || offer_live || expected_bytes.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed pass at the reset byte order (little endian), no idling.
    // Fill the expression to exactly the limit with the longest operands,
    // then walk every rejection and the address-operation check order.
    pending_reqs.push_back(mk(REQ_CLEAR, 8'h00, '0, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_LIT0, '0, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_CONST1U, 64'hff, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_CONST2S, 64'h1234_8001, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_CONST4U, 64'hdead_beef_cafe_f00d, '0, '0,
                              '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_CONSTU, '1, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_CONSTS, 64'h8000_0000_0000_0000, '0, '0,
                              '0));
    // bregx with both operands at ten bytes: the longest item
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_BREGX, '1, 64'h8000_0000_0000_0000, '0,
                              '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_PICK, 64'h1ff, '0, '0, '0));
    // Address operation ignores its opcode field
    pending_reqs.push_back(mk(REQ_ADDR, OPC_UNUSED, '1, '1, '1, '1));
    // Second address op that also does not fit: too long wins
    pending_reqs.push_back(mk(REQ_ADDR, 8'h00, '0, '0, 32'h0102_0304, 32'd9));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_DEREF_SIZE, 64'h8, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_NOP, '0, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_DEREF, '0, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_CLEAR, '1, '1, '1, '1, '1));
    pending_reqs.push_back(mk(REQ_ADDR, 8'h00, '0, '0, 32'h0, 32'h0));
    pending_reqs.push_back(mk(REQ_ADDR, 8'h00, '0, '0, 32'h1234_5678, 32'd7));
    pending_reqs.push_back(mk(REQ_GENERIC, OP_ADDR, 64'h55, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_CONST8U, '1, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_CONST8S, '1, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_SKIP, 64'h10, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_BRA, 64'h10, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_UNUSED, '0, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_RESERVED, OPC_NOP, '0, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_BREG0, '1, '0, '0, '0));
    pending_reqs.push_back(mk(REQ_GENERIC, OPC_XDEREF_SIZE, 64'h0, '0, '0, '0));
    wait_drained();

    // Random phases, alternating byte order, each with its own idle pattern.
    // The last one holds the receiver off while the sender keeps offering,
    // so the output register fills and the block stops taking items.
    for (int p = 0; p < N_PHASES; p++) begin
      program_byte_order(~p[0]);
      send_idle_pct = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      for (int n = 0; n < PHASE_REQS; n++) pending_reqs.push_back(rand_request());
      if (p == N_PHASES - 1) begin
        @(posedge clk);
        stall_left = HOLD_CYCLES;
      end
      wait_drained();
    end

    // Allow the pipeline to settle; any stray result shows up in the monitor
    repeat (30) @(posedge clk);
    $display("Covered %0d items, %0d result bytes, both byte orders, five idle patterns.",
             items_taken, bytes_checked);
    $display("Statuses: ok %0d, bad op %0d, addr %0d, const8 %0d, branch %0d, long %0d, reloc %0d",
             status_hits[ST_OK], status_hits[ST_BAD_OP], status_hits[ST_ADDR_GEN],
             status_hits[ST_CONST8], status_hits[ST_BRANCH], status_hits[ST_TOO_LONG],
             status_hits[ST_RELOC2]);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Timeout: %0d results still owed", expected_bytes.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
